### hdl/sfp_pkg.sv
// Package for the serial frame parser: frame position codes, configuration and result types.
// Used by sfp_cfg_regs, sfp_parser and serial_frame_parser_checksum_core; no dependencies.
package sfp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DATA_BYTES = 4;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned SCALE_SH   = 4;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_TAIL_BYTE     = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        POS_HEADER1 = 3'd0,
        POS_HEADER2 = 3'd1,
        POS_DATA0   = 3'd2,
        POS_DATA1   = 3'd3,
        POS_DATA2   = 3'd4,
        POS_DATA3   = 3'd5,
        POS_CHECK   = 3'd6,
        POS_TAIL    = 3'd7
    } frame_pos_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] tail_byte;
    } cfg_t;

    typedef struct packed {
        logic              frame_done;
        logic [BYTE_W-1:0] right_x;
        logic [BYTE_W-1:0] right_value;
        logic [BYTE_W-1:0] left_x;
        logic [BYTE_W-1:0] left_value;
    } result_t;

endpackage

### hdl/sfp_cfg_regs.sv
// Configuration register file of the serial frame parser (header and tail bytes).
// Depends on sfp_pkg.
module sfp_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [sfp_pkg::BYTE_W-1:0]       wr_data,
    output sfp_pkg::cfg_t                    cfg
);

    sfp_pkg::cfg_t cfg_reg;
    sfp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sfp_pkg::cfg_index_t'(wr_index))
                sfp_pkg::REG_HEADER_FIRST:  cfg_next.header_first  = wr_data;
                sfp_pkg::REG_HEADER_SECOND: cfg_next.header_second = wr_data;
                sfp_pkg::REG_TAIL_BYTE:     cfg_next.tail_byte     = wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/sfp_parser.sv
// Frame parser state and per-byte step logic: position, held data bytes, latched outputs.
// Depends on sfp_pkg; result is the value after the stepped byte, to be registered by the caller.
module sfp_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  logic [sfp_pkg::BYTE_W-1:0]  rx_byte,
    input  sfp_pkg::cfg_t               cfg,
    output sfp_pkg::result_t            result
);

    sfp_pkg::frame_pos_t       pos_reg;
    sfp_pkg::frame_pos_t       pos_next;
    logic [sfp_pkg::BYTE_W-1:0] held_reg  [sfp_pkg::DATA_BYTES];
    logic [sfp_pkg::BYTE_W-1:0] held_next [sfp_pkg::DATA_BYTES];
    sfp_pkg::result_t          latch_reg;
    sfp_pkg::result_t          latch_next;

    logic [12:0]               partial_sum;
    logic [sfp_pkg::SUM_W-1:0] check_sum;
    logic                      byte_ok;

    // The check byte only matches when the wrapped 16-bit sum fits in one byte.
    assign partial_sum = {1'b0, held_reg[0], {sfp_pkg::SCALE_SH{1'b0}}}
                       + 13'(held_reg[1]) + 13'(held_reg[2]);
    assign check_sum   = 16'(partial_sum) - 16'(held_reg[3]);

    always_comb
    begin
        held_next  = held_reg;
        latch_next = latch_reg;
        latch_next.frame_done = 1'b0;
        pos_next   = sfp_pkg::POS_HEADER1;
        byte_ok    = 1'b0;

        unique case (pos_reg)
            sfp_pkg::POS_HEADER1: byte_ok = (rx_byte == cfg.header_first);
            sfp_pkg::POS_HEADER2: byte_ok = (rx_byte == cfg.header_second);
            sfp_pkg::POS_DATA0,
            sfp_pkg::POS_DATA1,
            sfp_pkg::POS_DATA2,
            sfp_pkg::POS_DATA3:   byte_ok = 1'b1;
            sfp_pkg::POS_CHECK:   byte_ok = (check_sum == 16'(rx_byte));
            sfp_pkg::POS_TAIL:    byte_ok = (rx_byte == cfg.tail_byte);
            default:              byte_ok = 1'b0;
        endcase

        if (byte_ok)
        begin
            unique case (pos_reg)
                sfp_pkg::POS_DATA0: held_next[0] = rx_byte;
                sfp_pkg::POS_DATA1: held_next[1] = rx_byte;
                sfp_pkg::POS_DATA2: held_next[2] = rx_byte;
                sfp_pkg::POS_DATA3: held_next[3] = rx_byte;
                default:            held_next = held_reg;
            endcase
            if (pos_reg == sfp_pkg::POS_TAIL)
            begin
                pos_next               = sfp_pkg::POS_HEADER1;
                latch_next.frame_done  = 1'b1;
                latch_next.left_value  = held_reg[0];
                latch_next.left_x      = held_reg[1];
                latch_next.right_value = held_reg[2];
                latch_next.right_x     = held_reg[3];
            end
            else
            begin
                pos_next = sfp_pkg::frame_pos_t'(pos_reg + 3'd1);
            end
        end
        else
        begin
            latch_next.left_value  = '0;
            latch_next.right_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= sfp_pkg::POS_HEADER1;
            held_reg  <= '{default: '0};
            latch_reg <= '0;
        end
        else if (step_en)
        begin
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            latch_reg <= latch_next;
        end
    end

    assign result = latch_next;

endmodule

### hdl/serial_frame_parser_checksum_core.sv
// Serial frame parser core: one received byte per transfer in, one result transfer out per byte.
// Each byte passes an input register, one step of the parser and an output register, so the
// block takes one byte per clock unless the output stalls; a stalled output holds its result
// while the input register still takes one more byte. Configuration writes are always accepted.
// Depends on sfp_pkg, sfp_cfg_regs and sfp_parser.
module serial_frame_parser_checksum_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [7:0] left_value, [15:8] left_x,
                                                        // [23:16] right_value, [31:24] right_x
    output logic                             m_tlast,   // frame_done
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfp_pkg::BYTE_W-1:0]       cfg_data
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [sfp_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    sfp_pkg::result_t            out_reg;
    sfp_pkg::result_t            step_result;
    sfp_pkg::cfg_t               cfg;
    logic                        advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    sfp_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sfp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_comb
    begin
        in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.frame_done;
    assign m_tdata  = {out_reg.right_x, out_reg.right_value, out_reg.left_x, out_reg.left_value};

`ifndef ASSERT_OFF
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("Parser step did not produce a pending result.");

    a_input_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("Accepted byte was not captured in the input register.");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("Waiting input byte was lost or changed.");

    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("Stalled result was dropped or changed.");
`endif

endmodule
